@@ design/colstat_pkg.sv @@
// Package for the column statistics block: sizes, payload and snapshot types,
// and the back-end state encoding. No dependencies.
package colstat_pkg;

   localparam int SampleBits  = 16;
   localparam int MaxSamples  = 65536;
   localparam int CountBits   = 17;
   localparam int SumBits     = 33;
   localparam int SqBits      = 47;
   localparam int MagBits     = 32;
   localparam int ProdBits    = 64;
   localparam int DivBits     = 64;
   localparam int DenBits     = 34;
   localparam int RootBits    = 32;
   localparam int StepBits    = 6;
   localparam int ALoBits     = 24;
   localparam int QueueDepth  = 2;

   typedef struct packed {
      logic [SampleBits-1:0] sample;
      logic                  missing;
      logic                  last;
   } req_payload_type;

   typedef struct packed {
      logic [CountBits-1:0]         present_count;
      logic signed [SampleBits-1:0] mean;
      logic [SampleBits-1:0]        std_dev;
      logic signed [SampleBits-1:0] min_value;
      logic signed [SampleBits-1:0] max_value;
      logic                         empty_res;
   } rsp_payload_type;

   // Accumulated statistics of one finished column.
   typedef struct packed {
      logic [CountBits-1:0]         count;
      logic signed [SumBits-1:0]    sum;
      logic [SqBits-1:0]            sumsq;
      logic signed [SampleBits-1:0] min_value;
      logic signed [SampleBits-1:0] max_value;
   } snap_type;

   typedef struct packed {
      logic     push;
      snap_type snap;
   } q_wr_type;

   typedef struct packed {
      logic     valid;
      snap_type snap;
   } q_rd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL_NN,
      BK_MUL_ALO,
      BK_MUL_AHI,
      BK_MUL_B,
      BK_SUB,
      BK_DIV_MEAN,
      BK_DIV_VAR,
      BK_SQRT,
      BK_DONE
   } back_state_type;

endpackage

@@ design/colstat_if.sv @@
// Valid/ready channel interfaces for the column statistics block.
// Depends on colstat_pkg for the payload types.
interface colstat_req_if import colstat_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface colstat_rsp_if import colstat_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/colstat_front.sv @@
// Front end: accepts samples, keeps the running count, sums, min and max,
// and pushes a snapshot on the last item. Depends on colstat_pkg, colstat_if.
module colstat_front import colstat_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   colstat_req_if.sink  req_chan,
   input  logic         q_full,
   output q_wr_type     q_wr
);

   logic [CountBits-1:0]         count_ff, count_in;
   logic signed [SumBits-1:0]    sum_ff, sum_in;
   logic [SqBits-1:0]            sumsq_ff, sumsq_in;
   logic signed [SampleBits-1:0] min_ff, min_in;
   logic signed [SampleBits-1:0] max_ff, max_in;
   logic                         seen_ff, seen_in;

   logic signed [SampleBits-1:0] s;
   logic [SampleBits:0]          ext;
   logic [SampleBits:0]          mag;
   logic [2*SampleBits-1:0]      square;
   logic                         take;
   logic                         accept;
   snap_type                     upd;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      s      = signed'(req_chan.data.sample[SampleBits-1:0]);
      ext    = {s[SampleBits-1], s};
      mag    = s[SampleBits-1] ? (~ext + 1'b1) : ext;
      square = mag[SampleBits-1:0] * mag[SampleBits-1:0];
      take   = !req_chan.data.missing && (count_ff < CountBits'(MaxSamples));

      upd.count     = count_ff;
      upd.sum       = sum_ff;
      upd.sumsq     = sumsq_ff;
      upd.min_value = min_ff;
      upd.max_value = max_ff;
      seen_in       = seen_ff;
      if (take) begin
         upd.count = count_ff + 1'b1;
         upd.sum   = sum_ff + SumBits'(s);
         upd.sumsq = sumsq_ff + SqBits'(square);
         if (!seen_ff || s < min_ff) begin
            upd.min_value = s;
         end
         if (!seen_ff || s > max_ff) begin
            upd.max_value = s;
         end
         seen_in = 1'b1;
      end

      count_in = upd.count;
      sum_in   = upd.sum;
      sumsq_in = upd.sumsq;
      min_in   = upd.min_value;
      max_in   = upd.max_value;

      q_wr.push = accept && req_chan.data.last;
      q_wr.snap = upd;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.data.last)) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         seen_ff  <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         seen_ff  <= seen_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.data.last) |=> (count_ff == '0 && !seen_ff))
      else $error("statistics not cleared after last item");

   a_seen_matches_count: assert property (@(posedge clock) disable iff (reset)
      seen_ff == (count_ff != '0))
      else $error("seen flag disagrees with count");

endmodule

@@ design/colstat_queue.sv @@
// Short snapshot queue between the front and back ends.
// Depends on colstat_pkg.
module colstat_queue import colstat_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  q_wr_type q_wr,
   input  logic     pop,
   output logic     full,
   output q_rd_type q_rd
);

   localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

   snap_type             mem_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntBits-1:0]   count_ff;
   logic                 do_pop;

   assign full       = count_ff == CntBits'(QUEUE_DEPTH);
   assign q_rd.valid = count_ff != '0;
   assign q_rd.snap  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && q_rd.valid;

   always_ff @(posedge clock) begin
      if (q_wr.push && !full) begin
         mem_ff[wr_ptr_ff] <= q_wr.snap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_wr.push && !full) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if ((q_wr.push && !full) && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!(q_wr.push && !full) && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !q_wr.push)
      else $error("snapshot pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

@@ design/colstat_back.sv @@
// Back end: turns a snapshot into mean, standard deviation and the result item
// with one shared multiplier, a shift-subtract divider and a digit-by-digit
// square root. Depends on colstat_pkg and colstat_if.
module colstat_back import colstat_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  q_rd_type       q_rd,
   output logic           pop,
   colstat_rsp_if.source  rsp_chan
);

   back_state_type state_ff, state_in;

   logic [CountBits-1:0]         n_ff;
   logic [SqBits-1:0]            sumsq_ff;
   logic                         neg_ff;
   logic [MagBits-1:0]           smag_ff;
   logic signed [SampleBits-1:0] min_ff, max_ff;
   logic                         empty_ff;
   logic [DenBits-1:0]           nn_ff;
   logic [ProdBits-1:0]          a_ff, b_ff;
   logic [DivBits-1:0]           num_ff;
   logic [DenBits-1:0]           den_ff;
   logic [DenBits-1:0]           rem_ff;
   logic [StepBits-1:0]          step_ff;
   logic [SampleBits-1:0]        mean_ff;
   logic [RootBits-1:0]          x_ff, root_ff, bit_ff;
   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_ff;

   logic [MagBits-1:0]   mul_a, mul_b;
   logic [ProdBits-1:0]  prod;
   logic [DenBits:0]     trial;
   logic                 qbit;
   logic [DenBits-1:0]   rem_next;
   logic [DivBits-1:0]   num_next;
   logic [SampleBits-1:0] qa;
   logic [RootBits-1:0]  rtrial;
   logic                 out_free;
   logic                 load_out;
   logic                 div_last, sqrt_last;
   logic [MagBits-1:0]   smag_in;
   logic [SumBits-1:0]   sum_abs;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign div_last  = step_ff == StepBits'(DivBits - 1);
   assign sqrt_last = step_ff == StepBits'(RootBits / 2 - 1);

   // One multiplier, its operands chosen by the step of the sequence.
   always_comb begin
      mul_a = MagBits'(n_ff);
      mul_b = MagBits'(n_ff);
      unique case (state_ff)
         BK_MUL_ALO: mul_b = MagBits'(sumsq_ff[ALoBits-1:0]);
         BK_MUL_AHI: mul_b = MagBits'(sumsq_ff[SqBits-1:ALoBits]);
         BK_MUL_B: begin
            mul_a = smag_ff;
            mul_b = smag_ff;
         end
         default: ;
      endcase
      prod = mul_a * mul_b;
   end

   // One restoring division step (mean, variance), root trial, sum magnitude.
   always_comb begin
      trial    = {rem_ff, num_ff[DivBits-1]};
      qbit     = trial >= {1'b0, den_ff};
      rem_next = qbit ? DenBits'(trial - {1'b0, den_ff}) : trial[DenBits-1:0];
      num_next = {num_ff[DivBits-2:0], qbit};
      qa       = num_next[SampleBits-1:0] + SampleBits'(rem_next != '0);
      rtrial   = root_ff + bit_ff;
      sum_abs  = q_rd.snap.sum[SumBits-1] ? (~q_rd.snap.sum + 1'b1) : q_rd.snap.sum;
      smag_in  = sum_abs[MagBits-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_rd.valid) begin
               state_in = (q_rd.snap.count == '0) ? BK_DONE : BK_MUL_NN;
            end
         end
         BK_MUL_NN:   state_in = BK_MUL_ALO;
         BK_MUL_ALO:  state_in = BK_MUL_AHI;
         BK_MUL_AHI:  state_in = BK_MUL_B;
         BK_MUL_B:    state_in = BK_SUB;
         BK_SUB:      state_in = BK_DIV_MEAN;
         BK_DIV_MEAN: state_in = div_last ? BK_DIV_VAR : BK_DIV_MEAN;
         BK_DIV_VAR:  state_in = div_last ? BK_SQRT : BK_DIV_VAR;
         BK_SQRT:     state_in = sqrt_last ? BK_DONE : BK_SQRT;
         BK_DONE:     state_in = out_free ? BK_IDLE : BK_DONE;
         default:     state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = (state_ff == BK_IDLE) && q_rd.valid;
      load_out = (state_ff == BK_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            n_ff     <= q_rd.snap.count;
            sumsq_ff <= q_rd.snap.sumsq;
            neg_ff   <= q_rd.snap.sum[SumBits-1];
            smag_ff  <= smag_in;
            min_ff   <= q_rd.snap.min_value;
            max_ff   <= q_rd.snap.max_value;
            empty_ff <= q_rd.snap.count == '0;
            root_ff  <= '0;
            mean_ff  <= '0;
         end
         BK_MUL_NN:  nn_ff <= prod[DenBits-1:0];
         BK_MUL_ALO: a_ff  <= prod;
         BK_MUL_AHI: a_ff  <= a_ff + (prod << ALoBits);
         BK_MUL_B:   b_ff  <= prod;
         BK_SUB: begin
            a_ff    <= (a_ff >= b_ff) ? (a_ff - b_ff) : '0;
            num_ff  <= DivBits'(smag_ff);
            den_ff  <= DenBits'(n_ff);
            rem_ff  <= '0;
            step_ff <= '0;
         end
         BK_DIV_MEAN: begin
            if (div_last) begin
               // Floor toward minus infinity for a negative sum.
               mean_ff <= neg_ff ? (~qa + 1'b1) : num_next[SampleBits-1:0];
               num_ff  <= a_ff;
               den_ff  <= nn_ff;
               rem_ff  <= '0;
               step_ff <= '0;
            end else begin
               num_ff  <= num_next;
               rem_ff  <= rem_next;
               step_ff <= step_ff + 1'b1;
            end
         end
         BK_DIV_VAR: begin
            if (div_last) begin
               x_ff    <= num_next[RootBits-1:0];
               root_ff <= '0;
               bit_ff  <= RootBits'(1) << (RootBits - 2);
               step_ff <= '0;
            end else begin
               num_ff  <= num_next;
               rem_ff  <= rem_next;
               step_ff <= step_ff + 1'b1;
            end
         end
         BK_SQRT: begin
            if (x_ff >= rtrial) begin
               x_ff    <= x_ff - rtrial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + 1'b1;
         end
         BK_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff.present_count <= empty_ff ? '0 : n_ff;
         rsp_ff.mean          <= empty_ff ? '0 : mean_ff;
         rsp_ff.std_dev       <= empty_ff ? '0 : root_ff[SampleBits-1:0];
         rsp_ff.min_value     <= empty_ff ? '0 : min_ff;
         rsp_ff.max_value     <= empty_ff ? '0 : max_ff;
         rsp_ff.empty_res     <= empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.empty_res) |->
         (rsp_ff.present_count == '0 && rsp_ff.std_dev == '0 && rsp_ff.mean == '0))
      else $error("empty column result carries nonzero fields");

   a_count_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.empty_res) |-> rsp_ff.present_count != '0)
      else $error("nonempty result with zero count");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == BK_MUL_NN || state_ff == BK_DONE))
      else $error("back end took a snapshot outside idle");

endmodule

@@ design/column_statistics.sv @@
// Column statistics: one signed Q8.8 sample per item; on the last item of a
// column one result item gives the present count, floor mean, floor standard
// deviation, minimum and maximum. The front end accumulates at one item per
// cycle while the queue is not full; each finished column is handed through a
// snapshot queue to a back end that takes a nonempty column through a load
// step, four multiply steps, a subtract, two 64-step divisions, a 16-step
// square root and a hand-off step, and an empty one through only the load and
// hand-off steps, before the output register. Columns may be as short as one
// item; the input stalls only when the queue is full, so sustained rate is one
// item per cycle for columns longer than the back-end time.
// Depends on colstat_pkg, colstat_if, colstat_front, colstat_queue, colstat_back.
module column_statistics import colstat_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic           clock,
   input  logic           reset,
   colstat_req_if.sink    req_chan,
   colstat_rsp_if.source  rsp_chan
);

   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full;
   logic     q_pop;

   colstat_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_wr     (q_wr)
   );

   colstat_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (q_pop),
      .full  (q_full),
      .q_rd  (q_rd)
   );

   colstat_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rd     (q_rd),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ verif/column_statistics_test.sv @@
// Testbench for column_statistics: drives columns of Q8.8 samples with missing
// and last flags, predicts each column's statistics and checks every result item.
// Depends on colstat_pkg, colstat_if and the column_statistics RTL.
`timescale 1ns / 100ps
module column_statistics_test;
   import colstat_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic clock;
   logic reset;

   colstat_req_if req_chan ();
   colstat_rsp_if rsp_chan ();

   column_statistics dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Predictor state for the column being accumulated.
   logic [CountBits-1:0]         acc_count;
   logic signed [63:0]           acc_sum;
   logic [63:0]                  acc_sumsq;
   logic signed [SampleBits-1:0] acc_min;
   logic signed [SampleBits-1:0] acc_max;
   logic                         acc_seen;

   req_payload_type pending_items[$];
   rsp_payload_type expected_stats[$];

   int  mismatch_count;
   int  idle_cycles;
   bit  stimulus_done;
   int  send_gap;
   int  recv_gap;
   int  hold_off;
   bit  hold_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   task automatic clear_column();
      acc_count = 0;
      acc_sum = 0;
      acc_sumsq = 0;
      acc_min = 0;
      acc_max = 0;
      acc_seen = 0;
   endtask

   task automatic predict_item(req_payload_type item);
      logic signed [63:0] s;
      logic [63:0] mag;
      logic [63:0] n;
      logic signed [63:0] q;
      logic signed [63:0] r;
      logic [63:0] smag;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] var_v;
      rsp_payload_type res;
      s = 64'(signed'(item.sample));
      if (!item.missing && acc_count < MaxSamples) begin
         mag = (s < 0) ? -s : s;
         acc_count++;
         acc_sum += s;
         acc_sumsq += mag * mag;
         if (!acc_seen || s < acc_min) acc_min = item.sample;
         if (!acc_seen || s > acc_max) acc_max = item.sample;
         acc_seen = 1;
      end
      if (item.last) begin
         res = '0;
         if (acc_count == 0) begin
            res.empty_res = 1'b1;
         end else begin
            n = 64'(acc_count);
            q = acc_sum / signed'(n);
            r = acc_sum % signed'(n);
            if (r != 0 && acc_sum < 0) q--;
            smag = (acc_sum < 0) ? -acc_sum : acc_sum;
            a = n * acc_sumsq;
            b = smag * smag;
            var_v = (a >= b) ? (a - b) / (n * n) : 0;
            res.present_count = acc_count;
            res.mean = q[15:0];
            res.std_dev = 16'(floor_sqrt(var_v));
            res.min_value = acc_min;
            res.max_value = acc_max;
         end
         expected_stats = {expected_stats, res};
         clear_column();
      end
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(signed'($urandom_range(0, 512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_item(logic [15:0] s, logic m, logic l);
      req_payload_type item;
      item.sample = s;
      item.missing = m;
      item.last = l;
      pending_items = {pending_items, item};
   endtask

   function automatic int random_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   initial begin
      int len;
      int total;
      clear_column();
      // Directed: extremes, single item columns, empty and all-missing columns.
      add_item(16'h7FFF, 0, 1);
      add_item(16'h8000, 0, 1);
      add_item(16'h0000, 0, 1);
      add_item(16'h1234, 1, 1);
      add_item(16'h8000, 1, 0);
      add_item(16'h7FFF, 1, 1);
      add_item(16'h8000, 0, 0);
      add_item(16'h7FFF, 0, 0);
      add_item(16'h8000, 0, 0);
      add_item(16'h7FFF, 0, 1);
      add_item(16'hFFFF, 0, 0);
      add_item(16'h0001, 0, 0);
      add_item(16'h5555, 1, 1);
      add_item(16'hFFFE, 0, 0);
      add_item(16'hFFFF, 0, 0);
      add_item(16'hAAAA, 0, 1);
      add_item(16'h0100, 0, 0);
      add_item(16'h0200, 0, 0);
      add_item(16'h0300, 1, 1);
      total = 0;
      while (total < 500) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++)
            add_item(random_sample(), $urandom_range(0, 4) == 0, i == len - 1);
         total += len;
      end
      // A tail of short columns to fill the snapshot queue during the long hold-off.
      for (int i = 0; i < 12; i++) add_item(random_sample(), 0, 1);
   end

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.data <= '0;
         send_gap <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) predict_item(req_chan.data);
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_items.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.data <= pending_items.pop_front();
            send_gap <= random_gap();
         end else begin
            req_chan.valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Receiver, with one long hold-off once fewer than ten items remain to be sent.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap <= 0;
         hold_off <= 0;
         hold_done <= 0;
      end else if (!hold_done && pending_items.size() < 10) begin
         rsp_chan.ready <= 1'b0;
         hold_off <= hold_off + 1;
         if (hold_off >= 599) hold_done <= 1'b1;
      end else begin
         if (recv_gap > 0) begin
            rsp_chan.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
            recv_gap <= random_gap();
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (expected_stats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result item %p", got);
         end else begin
            want = expected_stats.pop_front();
            if (got.present_count !== want.present_count || got.mean !== want.mean ||
                got.std_dev !== want.std_dev || got.min_value !== want.min_value ||
                got.max_value !== want.max_value || got.empty_res !== want.empty_res) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("column_statistics test failed");
         $finish;
      end
   end

   initial begin
      mismatch_count = 0;
      idle_cycles = 0;
      stimulus_done = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_stats.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_stats.size() == 0)
         $display("column_statistics test passed");
      else
         $display("column_statistics test failed");
      $finish;
   end

endmodule
